// File: rtl/core/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg: shared types and codes for the number redirect table
// Request, response, queued command and table entry formats.
// ----------------------------------------------------------------------------
package nrt_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int NUM_DICTS_DEF   = 16;
	localparam int MAX_DIGITS_DEF  = 16;

	// operation codes
	localparam logic [2:0] OP_CREATE    = 3'd0;
	localparam logic [2:0] OP_DELETE    = 3'd1;
	localparam logic [2:0] OP_INSERT    = 3'd2;
	localparam logic [2:0] OP_ERASE     = 3'd3;
	localparam logic [2:0] OP_XFORM     = 3'd4;
	localparam logic [2:0] OP_CYCLIC    = 3'd5;
	localparam logic [2:0] OP_XFORM_ALL = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_DICT = 3'd1;
	localparam logic [2:0] ST_BAD_NUM  = 3'd2;
	localparam logic [2:0] ST_CYCLIC   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_NO_ID    = 3'd6;

	// command kinds handed from front to back
	localparam logic [2:0] K_DONE   = 3'd0;
	localparam logic [2:0] K_DELETE = 3'd1;
	localparam logic [2:0] K_INSERT = 3'd2;
	localparam logic [2:0] K_ERASE  = 3'd3;
	localparam logic [2:0] K_XFORM  = 3'd4;
	localparam logic [2:0] K_CYCLIC = 3'd5;
	localparam logic [2:0] K_FULL   = 3'd6;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  dict_id;
		logic [63:0] src_digits;
		logic [4:0]  src_len;
		logic [63:0] dst_digits;
		logic [4:0]  dst_len;
		logic [7:0]  buffer_len;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] result_digits;
		logic [4:0]  result_len;
		logic        cyclic_flag;
		logic [3:0]  new_dict_id;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  dict_id;
		logic [63:0] key;
		logic [4:0]  key_len;
		logic [63:0] dst;
		logic [4:0]  dst_len;
		logic [7:0]  buffer_len;
		logic [2:0]  status;
		logic [3:0]  new_id;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  owner;
		logic [63:0] key;
		logic [4:0]  key_len;
		logic [63:0] value;
		logic [4:0]  value_len;
	} entry_t;

endpackage

// File: rtl/core/nrt_front.sv
// ----------------------------------------------------------------------------
// nrt_front: request intake and classification
// Tracks live dictionaries and id issue, validates and masks numbers, and
// turns each request into a command for the table engine.
// ----------------------------------------------------------------------------
module nrt_front #(
	parameter int NUM_DICTS  = nrt_pkg::NUM_DICTS_DEF,
	parameter int MAX_DIGITS = nrt_pkg::MAX_DIGITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nrt_pkg::req_t in_data,
	input  logic          q_full,
	output logic          q_push,
	output nrt_pkg::cmd_t q_data
);
	import nrt_pkg::*;

	localparam int ID_W       = $clog2(NUM_DICTS + 1);
	localparam int DICT_SLOTS = (NUM_DICTS < 16) ? NUM_DICTS : 16;

	logic [DICT_SLOTS-1:0] live_q;
	logic [ID_W-1:0]       next_id_q;
	logic                  accept;
	logic                  live_hit;
	logic                  src_ok, dst_ok;
	logic [63:0]           src_m, dst_m;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	// dictionary liveness lookup
	always_comb begin
		live_hit = 1'b0;
		for (int k = 0; k < DICT_SLOTS; k++) begin
			if (in_data.dict_id == 4'(k) && live_q[k]) live_hit = 1'b1;
		end
	end

	// digit check and masking beyond length
	always_comb begin
		src_ok = (in_data.src_len != 5'd0) && (int'(in_data.src_len) <= MAX_DIGITS);
		dst_ok = (in_data.dst_len != 5'd0) && (int'(in_data.dst_len) <= MAX_DIGITS);
		src_m  = '0;
		dst_m  = '0;
		for (int i = 0; i < 16; i++) begin
			if (in_data.src_len > 5'(i)) begin
				src_m[4*i +: 4] = in_data.src_digits[4*i +: 4];
				if (in_data.src_digits[4*i +: 4] > 4'd9) src_ok = 1'b0;
			end
			if (in_data.dst_len > 5'(i)) begin
				dst_m[4*i +: 4] = in_data.dst_digits[4*i +: 4];
				if (in_data.dst_digits[4*i +: 4] > 4'd9) dst_ok = 1'b0;
			end
		end
	end

	// classification
	always_comb begin
		q_data            = '0;
		q_data.kind       = K_DONE;
		q_data.status     = ST_OK;
		q_data.dict_id    = in_data.dict_id;
		q_data.key        = src_m;
		q_data.key_len    = in_data.src_len;
		q_data.dst        = dst_m;
		q_data.dst_len    = in_data.dst_len;
		q_data.buffer_len = in_data.buffer_len;
		if (in_data.op == OP_CREATE) begin
			if (int'(next_id_q) >= NUM_DICTS) q_data.status = ST_NO_ID;
			else q_data.new_id = 4'(next_id_q);
		end else if (in_data.op <= OP_XFORM_ALL) begin
			if (!live_hit) begin
				q_data.status = ST_BAD_DICT;
			end else if (in_data.op == OP_DELETE) begin
				q_data.kind = K_DELETE;
			end else if (!src_ok) begin
				q_data.status = ST_BAD_NUM;
			end else begin
				case (in_data.op)
					OP_INSERT: begin
						if (dst_ok) q_data.kind = K_INSERT;
						else q_data.status = ST_BAD_NUM;
					end
					OP_ERASE:  q_data.kind = K_ERASE;
					OP_XFORM:  q_data.kind = K_XFORM;
					OP_CYCLIC: q_data.kind = K_CYCLIC;
					default:   q_data.kind = K_FULL;
				endcase
			end
		end
	end

	// dictionary bookkeeping in request order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			next_id_q <= '0;
		end else if (accept) begin
			if (in_data.op == OP_CREATE && int'(next_id_q) < NUM_DICTS) begin
				next_id_q <= next_id_q + 1'b1;
				for (int k = 0; k < DICT_SLOTS; k++) begin
					if (next_id_q == ID_W'(k)) live_q[k] <= 1'b1;
				end
			end
			if (in_data.op == OP_DELETE && live_hit) begin
				for (int k = 0; k < DICT_SLOTS; k++) begin
					if (in_data.dict_id == 4'(k)) live_q[k] <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/core/nrt_queue.sv
// ----------------------------------------------------------------------------
// nrt_queue: two-entry command queue
// Decouples request intake from the table engine.
// ----------------------------------------------------------------------------
module nrt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nrt_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output nrt_pkg::cmd_t head
);
	import nrt_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/core/nrt_back.sv
// ----------------------------------------------------------------------------
// nrt_back: table engine
// Holds the shared entry store and carries out commands by scanning it one
// entry per cycle; chain operations repeat the scan along redirections.
// ----------------------------------------------------------------------------
module nrt_back #(
	parameter int TABLE_DEPTH = nrt_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  nrt_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output nrt_pkg::rsp_t out_data
);
	import nrt_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(TABLE_DEPTH + 2);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	entry_t                 mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] used_q;
	logic                   state_q;
	cmd_t                   cmd_q;
	logic [63:0]            key_q, ad_q;
	logic [4:0]             key_len_q, al_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [STEP_W-1:0]      steps_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	entry_t                 rd_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   vld_s1;
	logic                   out_valid_q;
	rsp_t                   out_q;

	logic             used_s1, hit, last, end_evt, issue, restart, fin;
	logic             free_now, wr_en;
	logic [IDX_W-1:0] free_sel, wr_idx;
	rsp_t             rsp_n;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid && (!out_valid_q || out_ready);

	// compare stage
	assign used_s1 = used_q[idx_s1];
	assign hit     = vld_s1 && used_s1 && (rd_s1.owner == cmd_q.dict_id) &&
		(cmd_q.kind == K_DELETE || (rd_s1.key_len == key_len_q && rd_s1.key == key_q));
	assign last    = vld_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
	assign end_evt = (state_q == S_SCAN) && ((hit && cmd_q.kind != K_DELETE) || last);
	assign restart = end_evt && hit && (cmd_q.kind == K_CYCLIC || cmd_q.kind == K_FULL) &&
		(steps_q != STEP_W'(TABLE_DEPTH));
	assign issue   = (state_q == S_SCAN) && !end_evt && (cnt_q < CNT_W'(TABLE_DEPTH));

	assign free_now = free_found_q || (vld_s1 && !used_s1);
	assign free_sel = free_found_q ? free_idx_q : idx_s1;
	assign wr_en    = end_evt && cmd_q.kind == K_INSERT && (hit || free_now);
	assign wr_idx   = hit ? idx_s1 : free_sel;

	// result length check against caller buffer
	function automatic rsp_t len_check(logic [63:0] d, logic [4:0] l, logic [7:0] b);
		rsp_t r;
		r = '0;
		if ({3'b000, l} >= b) begin
			r.status = ST_TOO_LONG;
		end else begin
			r.result_digits = d;
			r.result_len    = l;
		end
		return r;
	endfunction

	// completion and response
	always_comb begin
		fin   = 1'b0;
		rsp_n = '0;
		if (q_pop && q_head.kind == K_DONE) begin
			fin               = 1'b1;
			rsp_n.status      = q_head.status;
			rsp_n.new_dict_id = q_head.new_id;
		end else if (end_evt && !restart) begin
			fin = 1'b1;
			case (cmd_q.kind)
				K_INSERT: rsp_n.status = (hit || free_now) ? ST_OK : ST_FULL;
				K_XFORM: begin
					if (hit) rsp_n = len_check(rd_s1.value, rd_s1.value_len, cmd_q.buffer_len);
					else rsp_n = len_check(key_q, key_len_q, cmd_q.buffer_len);
				end
				K_CYCLIC: rsp_n.cyclic_flag = hit;
				K_FULL: begin
					if (hit) begin
						rsp_n.status      = ST_CYCLIC;
						rsp_n.cyclic_flag = 1'b1;
					end else begin
						rsp_n = len_check(ad_q, al_q, cmd_q.buffer_len);
					end
				end
				default: rsp_n.status = ST_OK;
			endcase
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (issue) rd_s1 <= mem[cnt_q[IDX_W-1:0]];
		if (wr_en) mem[wr_idx] <= '{owner: cmd_q.dict_id, key: key_q, key_len: key_len_q,
			value: cmd_q.dst, value_len: cmd_q.dst_len};
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (issue) idx_s1 <= cnt_q[IDX_W-1:0];
		if (q_pop) begin
			cmd_q     <= q_head;
			key_q     <= q_head.key;
			key_len_q <= q_head.key_len;
			ad_q      <= q_head.key;
			al_q      <= q_head.key_len;
		end else if (restart) begin
			key_q     <= rd_s1.value;
			key_len_q <= rd_s1.value_len;
			ad_q      <= rd_s1.value;
			al_q      <= rd_s1.value_len;
		end
		if (q_pop || restart) begin
			free_found_q <= 1'b0;
		end else if (vld_s1 && !used_s1 && !free_found_q) begin
			free_found_q <= 1'b1;
			free_idx_q   <= idx_s1;
		end
	end

	// sequencer, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			cnt_q       <= '0;
			steps_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			vld_s1 <= issue;
			if (issue) cnt_q <= cnt_q + 1'b1;
			if (q_pop) begin
				cnt_q   <= '0;
				steps_q <= '0;
				if (q_head.kind != K_DONE) state_q <= S_SCAN;
			end else if (restart) begin
				cnt_q   <= '0;
				steps_q <= steps_q + 1'b1;
			end else if (end_evt) begin
				state_q <= S_IDLE;
			end
			if (state_q == S_SCAN && hit &&
				(cmd_q.kind == K_DELETE || cmd_q.kind == K_ERASE)) begin
				used_q[idx_s1] <= 1'b0;
			end
			if (wr_en) used_q[wr_idx] <= 1'b1;
			if (fin) begin
				out_valid_q <= 1'b1;
				out_q       <= rsp_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a new command starts only with the engine idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE)
		else $error("command taken while engine busy");

	// a response never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_valid_q || out_ready))
		else $error("response overwritten");

	// cyclic status always carries the cycle flag
	a_cyc_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_CYCLIC) |-> out_q.cyclic_flag)
		else $error("cyclic status without flag");

	// a result number comes only with ok status
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_len != 5'd0) |-> out_q.status == ST_OK)
		else $error("result number with error status");

endmodule

// File: rtl/core/number_redirect_table_core.sv
// ----------------------------------------------------------------------------
// number_redirect_table_core: shared phone-number redirection table
// Dictionary management, insert/erase and chain transforms over one store.
// ----------------------------------------------------------------------------
// Each transaction gives exactly one response, in order. With the engine idle,
// create, delete of a bad dictionary and rejected numbers are answered from the
// queue through the output register, without a scan. Every table lookup is a
// scan of the single-port entry memory, one entry per cycle, so insert, erase,
// transform and delete read up to TABLE_DEPTH entries (a hit ends the scan
// early, except for delete). Cycle test and full transform repeat the scan
// once per redirection along a long or cyclic chain.
// A two-entry queue lets requests be taken while the engine is busy and the
// output register holds a response until it is taken. No clearing pass.
module number_redirect_table_core #(
	parameter int TABLE_DEPTH = nrt_pkg::TABLE_DEPTH_DEF,
	parameter int NUM_DICTS   = nrt_pkg::NUM_DICTS_DEF,
	parameter int MAX_DIGITS  = nrt_pkg::MAX_DIGITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nrt_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output nrt_pkg::rsp_t out_data
);
	import nrt_pkg::*;

	cmd_t push_data, head;
	logic push, full, pop, not_empty;

	// intake and classification
	nrt_front #(.NUM_DICTS(NUM_DICTS), .MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_full(full), .q_push(push), .q_data(push_data)
	);

	// command queue
	nrt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .not_empty(not_empty), .head(head)
	);

	// table engine
	nrt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(not_empty), .q_head(head), .q_pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
